@@ src/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg
// Shared widths, constants, the frequency step table and types for the
// thermal step throttle.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int KHZ_W       = 22;
  localparam int TEMP_W      = 9;
  localparam int MAXT_W      = 7;
  localparam int STEP_IDX_W  = 5;
  localparam int TABLE_DEPTH = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int NUM_STEPS_DEF = 18;
  localparam int NUM_STEPS_MIN = 2;
  localparam int NUM_STEPS_MAX = 32;

  localparam logic signed [TEMP_W-1:0] SHUTDOWN_C = 9'sd110;
  localparam logic signed [TEMP_W-1:0] AVOID_C    = 9'sd105;
  localparam logic signed [TEMP_W:0]   HYST_C     = 10'sd5;

  localparam logic [MAXT_W-1:0] TRIP_RST    = 7'd65;
  localparam logic [KHZ_W-1:0]  CEILING_RST = 22'd2808000;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_C      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_KHZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ENABLE = 2'd2;

  // result of the step rule for one tick
  typedef struct packed {
    logic [KHZ_W-1:0] req_khz;
    logic             halt;
  } tst_rule_t;

  function automatic logic [KHZ_W-1:0] step_khz(input logic [STEP_IDX_W-1:0] idx);
    logic [KHZ_W-1:0] f;
    case (idx)
      5'd0:    f = 22'd741000;
      5'd1:    f = 22'd858000;
      5'd2:    f = 22'd962000;
      5'd3:    f = 22'd1066000;
      5'd4:    f = 22'd1170000;
      5'd5:    f = 22'd1261000;
      5'd6:    f = 22'd1469000;
      5'd7:    f = 22'd1703000;
      5'd8:    f = 22'd1807000;
      5'd9:    f = 22'd1937000;
      5'd10:   f = 22'd2002000;
      5'd11:   f = 22'd2158000;
      5'd12:   f = 22'd2314000;
      5'd13:   f = 22'd2496000;
      5'd14:   f = 22'd2574000;
      5'd15:   f = 22'd2652000;
      5'd16:   f = 22'd2704000;
      default: f = 22'd2808000;
    endcase
    return f;
  endfunction

endpackage

@@ src/tst_step_rule.sv @@
// ----------------------------------------------------------------------------
// tst_step_rule
// Temperature rule: picks the next requested limit from the current applied
// limit and the sample, and flags the shutdown condition.
// ----------------------------------------------------------------------------
module tst_step_rule #(
  parameter int NUM_STEPS = tst_pkg::NUM_STEPS_DEF
) (
  input  logic        [tst_pkg::KHZ_W-1:0]  applied_khz,
  input  logic        [tst_pkg::KHZ_W-1:0]  requested_khz,
  input  logic signed [tst_pkg::TEMP_W-1:0] temperature,
  input  logic        [tst_pkg::MAXT_W-1:0] trip_c,
  output tst_pkg::tst_rule_t                rule
);
  import tst_pkg::*;

  localparam int N = (NUM_STEPS < NUM_STEPS_MIN) ? NUM_STEPS_MIN :
                     (NUM_STEPS > NUM_STEPS_MAX) ? NUM_STEPS_MAX : NUM_STEPS;
  localparam int F = (N > 4) ? N - 4 : 1;

  localparam logic [STEP_IDX_W-1:0] F_IDX  = STEP_IDX_W'(F);
  localparam logic [STEP_IDX_W-1:0] F1_IDX = STEP_IDX_W'(F - 1);

  logic signed [TEMP_W-1:0] maxt_s;
  logic signed [TEMP_W:0]   temp_w;
  logic signed [TEMP_W:0]   up_thr;
  logic                     down_hit;
  logic [KHZ_W-1:0]         down_khz;
  logic                     up_hit;
  logic [KHZ_W-1:0]         up_khz;

  assign maxt_s = signed'({2'b00, trip_c});
  assign temp_w = {temperature[TEMP_W-1], temperature};
  assign up_thr = signed'({3'b000, trip_c}) - HYST_C;

  // step down: highest matching entry below the fast-drop index wins
  always_comb begin
    down_hit = 1'b0;
    down_khz = requested_khz;
    for (int k = 1; k <= F - 1; k++) begin
      if (applied_khz == step_khz(STEP_IDX_W'(k))) begin
        down_hit = 1'b1;
        down_khz = step_khz(STEP_IDX_W'(k - 1));
      end
    end
  end

  // step up: lowest matching entry wins
  always_comb begin
    up_hit = 1'b0;
    up_khz = requested_khz;
    for (int k = N - 2; k >= 0; k--) begin
      if (applied_khz == step_khz(STEP_IDX_W'(k))) begin
        up_hit = 1'b1;
        up_khz = step_khz(STEP_IDX_W'(k + 1));
      end
    end
  end

  always_comb begin
    rule.req_khz = requested_khz;
    rule.halt    = 1'b0;
    if (temperature >= SHUTDOWN_C) begin
      rule.req_khz = step_khz('0);
      rule.halt    = 1'b1;
    end else if (temperature >= AVOID_C) begin
      rule.req_khz = step_khz('0);
    end else if (temperature >= maxt_s) begin
      if (applied_khz >= step_khz(F_IDX)) begin
        rule.req_khz = step_khz(F1_IDX);
      end else if (down_hit) begin
        rule.req_khz = down_khz;
      end
    end else if (temp_w < up_thr) begin
      if (up_hit) begin
        rule.req_khz = up_khz;
      end
    end
  end

endmodule

@@ src/thermal_step_throttle.sv @@
// ----------------------------------------------------------------------------
// thermal_step_throttle
// Steps a frequency limit along a kHz table from die temperature ticks, with
// hysteresis, a ceiling clamp, a shutdown halt and an optional peak tracker.
// ----------------------------------------------------------------------------
// Timing: the result is registered and valid in the cycle after its input transfer.
// Throughput: one tick per cycle while the result channel is not stalled; the rule and
//   the state update sit in one compare-and-select pass ahead of the result register.
// Reset (rst_n low, synchronous): registers return to trip threshold 65 C,
//   ceiling 2808000 kHz, peak tracking off; limits, peak and flags clear.
module thermal_step_throttle #(
  parameter int NUM_STEPS = tst_pkg::NUM_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write port
  input  logic                           cfg_wr_en,
  input  logic [tst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tst_pkg::KHZ_W-1:0]      cfg_wdata,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [8:0] temperature, [9] clear_peak
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata   // [21:0] limit_khz, [22] limit_changed,
                                                     // [23] shutdown, [32:24] peak
);
  import tst_pkg::*;

  // configuration
  logic [MAXT_W-1:0] trip_c_r;
  logic [KHZ_W-1:0]  ceiling_r;
  logic              peak_en_r;

  // block state
  logic                     started_r, started_nxt;
  logic                     halted_r, halted_nxt;
  logic [KHZ_W-1:0]         requested_r, requested_nxt;
  logic [KHZ_W-1:0]         applied_r, applied_nxt;
  logic signed [TEMP_W-1:0] peak_r, peak_nxt;

  // result register
  logic        out_valid_r;
  logic [39:0] out_data_r, out_data_nxt;

  logic                     in_xfer;
  logic signed [TEMP_W-1:0] temp;
  logic                     clear_peak;
  logic                     start_now;
  logic                     run;
  logic [KHZ_W-1:0]         applied_cur;
  logic [KHZ_W-1:0]         req_cur;
  logic signed [TEMP_W-1:0] peak_base;
  tst_rule_t                rule;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign temp       = signed'(in_tdata[TEMP_W-1:0]);
  assign clear_peak = in_tdata[TEMP_W];

  // first tick with a nonzero ceiling loads both limits from it
  assign start_now   = !halted_r && !started_r && (ceiling_r != '0);
  assign run         = (started_r || start_now) && !halted_r;
  assign applied_cur = start_now ? ceiling_r : applied_r;
  assign req_cur     = start_now ? ceiling_r : requested_r;

  tst_step_rule #(
    .NUM_STEPS (NUM_STEPS)
  ) u_rule (
    .applied_khz   (applied_cur),
    .requested_khz (req_cur),
    .temperature   (temp),
    .trip_c        (trip_c_r),
    .rule          (rule)
  );

  always_comb begin
    started_nxt   = started_r || start_now;
    halted_nxt    = halted_r;
    requested_nxt = requested_r;
    applied_nxt   = applied_r;
    peak_base     = clear_peak ? '0 : peak_r;
    peak_nxt      = peak_base;
    if (run) begin
      if (peak_en_r && (temp > peak_base)) begin
        peak_nxt = temp;
      end
      requested_nxt = rule.req_khz;
      applied_nxt   = (rule.req_khz > ceiling_r) ? ceiling_r : rule.req_khz;
      halted_nxt    = rule.halt;
    end
    out_data_nxt = {7'b0, peak_nxt, halted_nxt, (applied_nxt != applied_r), applied_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_c_r  <= TRIP_RST;
      ceiling_r <= CEILING_RST;
      peak_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TRIP_C:      trip_c_r  <= cfg_wdata[MAXT_W-1:0];
        CFG_CEILING_KHZ: ceiling_r <= cfg_wdata;
        CFG_PEAK_ENABLE: peak_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      halted_r    <= 1'b0;
      requested_r <= '0;
      applied_r   <= '0;
      peak_r      <= '0;
    end else if (in_xfer) begin
      started_r   <= started_nxt;
      halted_r    <= halted_nxt;
      requested_r <= requested_nxt;
      applied_r   <= applied_nxt;
      peak_r      <= peak_nxt;
    end
  end

  // hold the result until its transfer; a new tick may load in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

@@ tb/thermal_step_throttle_test.sv @@
// ----------------------------------------------------------------------------
// thermal_step_throttle_test
// Self-checking bench for the thermal step throttle. A tick-level predictor
// tracks the start, step, clamp, shutdown and peak rules for every accepted
// tick. A monitor compares each result field by field against the oldest
// prediction. Directed ticks cover the corner cases, then phases of random
// hot, cold, hold and noise runs run under random register settings, with random
// gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermal_step_throttle_test;
  import tst_pkg::*;

  localparam int STEP_COUNT    = 18;
  localparam int FAST_IDX      = STEP_COUNT - 4;
  localparam int HOT_TOP       = 109;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_TICKS   = 100;
  localparam logic [KHZ_W-1:0] CEILING_TOP = 22'h3FFFFF;

  typedef struct packed {
    logic [KHZ_W-1:0]         limit_khz;
    logic                     limit_changed;
    logic                     shutdown;
    logic signed [TEMP_W-1:0] peak_c;
  } limit_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KHZ_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;

  // shadow registers and throttle state
  logic [MAXT_W-1:0]        thr_trip_c;
  logic [KHZ_W-1:0]         thr_ceiling;
  logic                     thr_peak_en;
  logic                     thr_started;
  logic                     thr_halted;
  logic [KHZ_W-1:0]         thr_req_khz;
  logic [KHZ_W-1:0]         thr_app_khz;
  logic signed [TEMP_W-1:0] thr_peak;

  limit_report_t due_reports[$];
  limit_report_t got_report;
  limit_report_t want_report;

  int fail_count;
  int idle_cycles = 0;
  bit gaps_on;
  bit stalls_on;
  bit idle_allowed;
  int stall_left = 0;

  thermal_step_throttle dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [8:0] temperature, [9] clear_peak
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // [21:0] limit_khz, [22] limit_changed,
                              // [23] shutdown, [32:24] peak
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [KHZ_W-1:0] khz_at_step(input int idx);
    logic [KHZ_W-1:0] f;
    case (idx)
      0:       f = 22'd741000;
      1:       f = 22'd858000;
      2:       f = 22'd962000;
      3:       f = 22'd1066000;
      4:       f = 22'd1170000;
      5:       f = 22'd1261000;
      6:       f = 22'd1469000;
      7:       f = 22'd1703000;
      8:       f = 22'd1807000;
      9:       f = 22'd1937000;
      10:      f = 22'd2002000;
      11:      f = 22'd2158000;
      12:      f = 22'd2314000;
      13:      f = 22'd2496000;
      14:      f = 22'd2574000;
      15:      f = 22'd2652000;
      16:      f = 22'd2704000;
      default: f = 22'd2808000;
    endcase
    return f;
  endfunction

  function automatic void reset_throttle_state();
    thr_trip_c   = TRIP_RST;
    thr_ceiling  = CEILING_RST;
    thr_peak_en  = 1'b0;
    thr_started  = 1'b0;
    thr_halted   = 1'b0;
    thr_req_khz  = '0;
    thr_app_khz  = '0;
    thr_peak     = '0;
  endfunction

  // Advance the shadow throttle by one tick and queue the result it must give.
  function automatic void predict_throttle(input logic signed [TEMP_W-1:0] temp,
                                           input logic clr);
    int               tv;
    int               mt;
    int               k;
    bit               hit;
    logic [KHZ_W-1:0] prior;
    limit_report_t    rep;
    tv    = temp;
    mt    = thr_trip_c;
    prior = thr_app_khz;
    hit   = 1'b0;
    if (clr) thr_peak = '0;
    if (!thr_halted && !thr_started && thr_ceiling != '0) begin
      thr_app_khz = thr_ceiling;
      thr_req_khz = thr_app_khz;
      thr_started = 1'b1;
    end
    if (thr_started && !thr_halted) begin
      if (thr_peak_en && temp > thr_peak) thr_peak = temp;
      if (tv >= SHUTDOWN_C) begin
        thr_req_khz = khz_at_step(0);
        thr_halted  = 1'b1;
      end else if (tv >= AVOID_C) begin
        thr_req_khz = khz_at_step(0);
      end else if (tv >= mt) begin
        // near the top of the table fall straight below the fast-drop entry
        if (thr_app_khz >= khz_at_step(FAST_IDX)) begin
          thr_req_khz = khz_at_step(FAST_IDX - 1);
        end else begin
          for (k = FAST_IDX - 1; k >= 1; k--) begin
            if (!hit && thr_app_khz == khz_at_step(k)) begin
              thr_req_khz = khz_at_step(k - 1);
              hit = 1'b1;
            end
          end
        end
      end else if (tv < mt - HYST_C) begin
        for (k = 0; k < STEP_COUNT - 1; k++) begin
          if (!hit && thr_app_khz == khz_at_step(k)) begin
            thr_req_khz = khz_at_step(k + 1);
            hit = 1'b1;
          end
        end
      end
      thr_app_khz = (thr_req_khz > thr_ceiling) ? thr_ceiling : thr_req_khz;
    end
    rep.limit_khz     = thr_app_khz;
    rep.limit_changed = (thr_app_khz != prior);
    rep.shutdown      = thr_halted;
    rep.peak_c        = thr_peak;
    due_reports.push_back(rep);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_report.limit_khz     = out_tdata[21:0];
      got_report.limit_changed = out_tdata[22];
      got_report.shutdown      = out_tdata[23];
      got_report.peak_c        = out_tdata[32:24];
      if (due_reports.size() == 0) begin
        $display("%0t unexpected result: expected none actual limit %0d", $time,
                 got_report.limit_khz);
        fail_count++;
      end else begin
        want_report = due_reports.pop_front();
        check_field("limit_khz", want_report.limit_khz, got_report.limit_khz);
        check_field("limit_changed", want_report.limit_changed,
                    got_report.limit_changed);
        check_field("shutdown", want_report.shutdown, got_report.shutdown);
        check_field("peak_c", $signed(want_report.peak_c),
                    $signed(got_report.peak_c));
      end
    end
  end

  // result-side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic signed [TEMP_W-1:0] temp, input logic clr);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, clr, temp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_throttle(temp, clr);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(input logic [MAXT_W-1:0] mt, input logic [KHZ_W-1:0] ceil,
                              input logic pe);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TRIP_C;
    cfg_wdata <= KHZ_W'(mt);
    @(posedge clk);
    cfg_index <= CFG_CEILING_KHZ;
    cfg_wdata <= ceil;
    @(posedge clk);
    cfg_index <= CFG_PEAK_ENABLE;
    cfg_wdata <= KHZ_W'(pe);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    thr_trip_c    = mt;
    thr_ceiling   = ceil;
    thr_peak_en   = pe;
  endtask

  // ticks before start with a zero ceiling are ignored
  task automatic test_zero_ceiling_start();
    apply_config(TRIP_RST, '0, 1'b1);
    send_tick(9'sd120, 1'b0);
    send_tick(-9'sd256, 1'b1);
    send_tick(9'sd0, 1'b0);
    wait_drain();
  endtask

  task automatic test_step_rules();
    apply_config(TRIP_RST, CEILING_RST, 1'b1);
    send_tick(9'sd20, 1'b0);    // start, then top entry has nowhere to rise
    send_tick(9'sd65, 1'b0);    // fast drop
    send_tick(9'sd65, 1'b0);    // one step down
    send_tick(9'sd62, 1'b0);    // hold inside hysteresis band
    send_tick(9'sd59, 1'b0);    // one step up
    send_tick(9'sd105, 1'b0);   // avoid temperature: lowest entry
    send_tick(9'sd104, 1'b1);   // already lowest, clear peak
    send_tick(-9'sd1, 1'b0);
    wait_drain();
  endtask

  task automatic test_ceiling_clamp();
    apply_config(TRIP_RST, 22'd2000000, 1'b0);
    send_tick(9'sd30, 1'b0);
    wait_drain();
    apply_config(TRIP_RST, '0, 1'b0);
    send_tick(9'sd30, 1'b0);
    wait_drain();
    apply_config(TRIP_RST, CEILING_TOP, 1'b0);
    send_tick(9'sd30, 1'b0);
    wait_drain();
  endtask

  task automatic test_threshold_extremes();
    apply_config(7'd0, CEILING_RST, 1'b0);
    send_tick(-9'sd3, 1'b0);
    send_tick(-9'sd6, 1'b0);
    wait_drain();
    apply_config(7'd127, CEILING_RST, 1'b0);
    send_tick(9'sd104, 1'b0);
    wait_drain();
  endtask

  task automatic test_peak_tracking();
    apply_config(TRIP_RST, CEILING_RST, 1'b1);
    send_tick(9'sd50, 1'b0);
    send_tick(9'sd40, 1'b1);
    send_tick(9'sd70, 1'b0);
    wait_drain();
  endtask

  task automatic pick_random_config();
    logic [MAXT_W-1:0] mt;
    logic [KHZ_W-1:0]  ceil;
    int                pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) mt = 7'd45;
    else if (pick == 1) mt = 7'd95;
    else if (pick == 2) mt = 7'd0;
    else if (pick == 3) mt = 7'd127;
    else mt = MAXT_W'(45 + $urandom_range(0, 50));
    pick = $urandom_range(0, 11);
    if (pick <= 4) ceil = CEILING_RST;
    else if (pick <= 7) ceil = khz_at_step($urandom_range(0, STEP_COUNT - 1));
    else if (pick == 8) ceil = KHZ_W'($urandom_range(0, 4194303));
    else if (pick == 9) ceil = CEILING_TOP;
    else if (pick == 10) ceil = '0;
    else ceil = KHZ_W'($urandom_range(741000, 2808000));
    apply_config(mt, ceil, 1'($urandom_range(0, 1)));
  endtask

  // runs of hot, cold, hold and noise ticks walk the limit along the table
  task automatic run_random_phase(input int count, input bit drain_midway);
    int   mode;
    int   run_left;
    int   lo;
    int   hi;
    int   mt;
    int   i;
    logic clr;
    run_left = 0;
    mode     = 0;
    mt       = thr_trip_c;
    for (i = 0; i < count; i++) begin
      if (drain_midway && i == count / 2) wait_drain();
      if (run_left == 0) begin
        mode     = $urandom_range(0, 9);
        run_left = $urandom_range(4, 24);
        if (idle_allowed) begin
          gaps_on   = ($urandom_range(0, 3) != 0);
          stalls_on = ($urandom_range(0, 3) != 0);
        end
      end
      if (mode <= 3) begin
        lo = mt;
        hi = mt + 4;
      end else if (mode <= 6) begin
        lo = mt - 20;
        hi = mt - 6;
      end else if (mode == 7) begin
        lo = mt - 5;
        hi = mt - 1;
      end else if (mode == 8) begin
        lo = AVOID_C;
        hi = HOT_TOP;
      end else begin
        lo = -256;
        hi = HOT_TOP;
      end
      if (hi > HOT_TOP) hi = HOT_TOP;
      if (lo > hi) lo = hi;
      clr = ($urandom_range(0, 15) == 0);
      send_tick(TEMP_W'(lo + $urandom_range(0, hi - lo)), clr);
      run_left--;
    end
  endtask

  task automatic test_random_phases();
    int p;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_drain();
      if (p == RANDOM_PHASES - 1) begin
        idle_allowed = 1'b0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b0;
      end
      pick_random_config();
      run_random_phase(PHASE_TICKS, p == 4);
    end
    wait_drain();
  endtask

  // shutdown halts the block until reset, so this runs last
  task automatic test_shutdown_halt();
    int i;
    apply_config(TRIP_RST, CEILING_RST, 1'b1);
    send_tick(9'sd110, 1'b0);
    send_tick(9'sd255, 1'b1);
    send_tick(-9'sd256, 1'b0);
    for (i = 0; i < 20; i++) begin
      send_tick(TEMP_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
    end
    wait_drain();
  endtask

  initial begin
    fail_count   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    idle_allowed = 1'b1;
    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= CFG_TRIP_C;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    reset_throttle_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_ceiling_start();
    test_step_rules();
    test_ceiling_clamp();
    test_threshold_extremes();
    test_peak_tracking();
    test_random_phases();
    test_shutdown_halt();

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
